/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RGBE scanline decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define RSRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked only while out of reset.
`define RSRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hw/rtl/rsrd_pkg.sv */
// Shared types and constants for the RGBE scanline RLE decoder.
`timescale 1ns / 1ps

package rsrd_pkg;

	localparam logic [1:0] KIND_CHAN     = 2'd0;
	localparam logic [1:0] KIND_PIXEL    = 2'd1;
	localparam logic [1:0] KIND_MISMATCH = 2'd2;
	localparam logic [1:0] KIND_OVERRUN  = 2'd3;

	localparam logic [14:0] LINE_WIDTH_RESET = 15'd512;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  channel;
		logic [14:0] x_start;
		logic [14:0] fill_count;
		logic [31:0] fill_value;
		logic        line_end;
	} result_t;

endpackage

/* hw/rtl/rsrd_byte_if.sv */
// Compressed byte channel: valid/ready handshake with byte and line start flag.
`timescale 1ns / 1ps

interface rsrd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       line_start;

	modport source (output valid, output data_byte, output line_start, input ready);
	modport sink (input valid, input data_byte, input line_start, output ready);
endinterface

/* hw/rtl/rsrd_fill_if.sv */
// Fill descriptor channel: valid/ready handshake with one decoded fill.
`timescale 1ns / 1ps

interface rsrd_fill_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  channel;
	logic [14:0] x_start;
	logic [14:0] fill_count;
	logic [31:0] fill_value;
	logic        line_end;

	modport source (output valid, output kind, output channel, output x_start,
		output fill_count, output fill_value, output line_end, input ready);
	modport sink (input valid, input kind, input channel, input x_start,
		input fill_count, input fill_value, input line_end, output ready);
endinterface

/* hw/rtl/rsrd_parser.sv */
// Scanline parser: per-byte state update and fill descriptor generation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsrd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 line_start,
	input  logic                 cfg_wr_en,
	input  logic [14:0]          cfg_wr_data,
	output logic                 res_valid,
	output rsrd_pkg::result_t    res
);

	typedef enum logic [2:0] {
		MODE_FIRST = 3'b001,
		MODE_OLD   = 3'b010,
		MODE_CHAN  = 3'b100
	} mode_t;

	typedef enum logic [3:0] {
		PH_CODE = 4'b0001,
		PH_RUN  = 4'b0010,
		PH_LIT  = 4'b0100,
		PH_LITC = 4'b1000
	} phase_t;

	logic [14:0] width_q;
	mode_t       mode_q, e_mode, n_mode;
	phase_t      phase_q, e_phase, n_phase;
	logic [1:0]  bip_q, e_bip, n_bip;
	logic [31:0] gather_q, e_gather, n_gather;
	logic [31:0] prev_q, n_prev;
	logic [1:0]  shift_q, e_shift, n_shift;
	logic [14:0] pos_q, e_pos, n_pos;
	logic [1:0]  ch_q, e_ch, n_ch;
	logic [7:0]  pend_q, e_pend, n_pend;
	logic        err_q, e_err, n_err;

	logic [14:0] left;
	logic [31:0] pix;
	logic [14:0] hdr_len;
	logic        last;
	logic        do_cf, cf_force, cf_over;
	logic [14:0] cf_k, cf_cnt;
	logic [7:0]  cf_val;
	logic        do_pf, pf_over;
	logic [31:0] pf_k, pf_val;
	logic        do_nl;

	// A line start clears the line state before this byte is parsed.
	always_comb begin
		e_mode   = line_start ? MODE_FIRST : mode_q;
		e_phase  = line_start ? PH_CODE : phase_q;
		e_bip    = line_start ? 2'd0 : bip_q;
		e_gather = line_start ? 32'd0 : gather_q;
		e_shift  = line_start ? 2'd0 : shift_q;
		e_pos    = line_start ? 15'd0 : pos_q;
		e_ch     = line_start ? 2'd0 : ch_q;
		e_pend   = line_start ? 8'd0 : pend_q;
		e_err    = line_start ? 1'b0 : err_q;
	end

	assign left = (width_q > e_pos) ? (width_q - e_pos) : 15'd0;
	assign pix = {data_byte, e_gather[23:0]};
	assign hdr_len = {pix[22:16], pix[31:24]};
	assign last = (e_pend <= 8'd1);

	always_comb begin
		n_mode   = e_mode;
		n_phase  = e_phase;
		n_bip    = e_bip;
		n_gather = e_gather;
		n_prev   = prev_q;
		n_shift  = e_shift;
		n_pos    = e_pos;
		n_ch     = e_ch;
		n_pend   = e_pend;
		n_err    = e_err;
		res_valid = 1'b0;
		res = '0;
		do_cf    = 1'b0;
		cf_k     = 15'd0;
		cf_val   = 8'd0;
		cf_force = 1'b0;
		cf_over  = 1'b0;
		cf_cnt   = 15'd0;
		do_pf    = 1'b0;
		pf_k     = 32'd0;
		pf_val   = 32'd0;
		pf_over  = 1'b0;
		do_nl    = 1'b0;

		if (!e_err) begin
			unique case (e_mode) inside
				MODE_CHAN: begin
					unique case (e_phase) inside
						PH_CODE: begin
							if (data_byte > 8'd128) begin
								n_pend  = {1'b0, data_byte[6:0]};
								n_phase = PH_RUN;
							end else if (data_byte != 8'd0) begin
								// cut a literal run that passes the line end
								if ({7'd0, data_byte} > left) begin
									n_pend  = left[7:0];
									n_phase = PH_LITC;
								end else begin
									n_pend  = data_byte;
									n_phase = PH_LIT;
								end
							end
						end
						PH_RUN: begin
							n_phase = PH_CODE;
							do_cf   = 1'b1;
							cf_k    = {7'd0, e_pend};
							cf_val  = data_byte;
						end
						PH_LIT, PH_LITC: begin
							cf_force = (e_phase == PH_LITC) && last;
							n_pend   = last ? 8'd0 : (e_pend - 8'd1);
							if (last) begin
								n_phase = PH_CODE;
							end
							do_cf  = 1'b1;
							cf_k   = 15'd1;
							cf_val = data_byte;
						end
						default: ;
					endcase
				end
				MODE_FIRST, MODE_OLD: begin
					n_gather = e_gather | ({24'd0, data_byte} << {e_bip, 3'b000});
					n_bip    = e_bip + 2'd1;
					if (e_bip == 2'd3) begin
						n_gather = 32'd0;
						if (e_mode == MODE_OLD) begin
							if (pix[7:0] == 8'd1 && pix[15:8] == 8'd1 && pix[23:16] == 8'd1) begin
								// repeat marker: count grows by a byte per marker in a row
								pf_k    = {24'd0, pix[31:24]} << {e_shift, 3'b000};
								n_shift = (e_shift == 2'd3) ? 2'd3 : (e_shift + 2'd1);
								do_pf   = (pix[31:24] != 8'd0);
								pf_val  = prev_q;
							end else begin
								n_prev  = pix;
								n_shift = 2'd0;
								do_pf   = 1'b1;
								pf_k    = 32'd1;
								pf_val  = pix;
							end
						end else if (pix[7:0] == 8'd2 && pix[15:8] == 8'd2 && !pix[23]) begin
							if (hdr_len != width_q) begin
								res_valid      = 1'b1;
								res.kind       = rsrd_pkg::KIND_MISMATCH;
								res.fill_value = {17'd0, hdr_len};
								res.line_end   = 1'b1;
								n_err          = 1'b1;
								do_nl          = 1'b1;
							end else if (hdr_len == 15'd0) begin
								res_valid    = 1'b1;
								res.kind     = rsrd_pkg::KIND_CHAN;
								res.channel  = 2'd3;
								res.line_end = 1'b1;
								do_nl        = 1'b1;
							end else begin
								n_mode  = MODE_CHAN;
								n_ch    = 2'd0;
								n_pos   = 15'd0;
								n_phase = PH_CODE;
								n_pend  = 8'd0;
							end
						end else begin
							n_mode  = MODE_OLD;
							n_shift = 2'd0;
							n_prev  = pix;
							do_pf   = 1'b1;
							pf_k    = 32'd1;
							pf_val  = pix;
						end
					end
				end
				default: ;
			endcase
		end

		if (do_cf) begin
			cf_over        = cf_k > left;
			cf_cnt         = cf_over ? left : cf_k;
			res_valid      = 1'b1;
			res.kind       = (cf_over || cf_force) ? rsrd_pkg::KIND_OVERRUN : rsrd_pkg::KIND_CHAN;
			res.channel    = e_ch;
			res.x_start    = e_pos;
			res.fill_count = cf_cnt;
			res.fill_value = {24'd0, cf_val};
			n_pos          = e_pos + cf_cnt;
			// channel done: advance to the next one, or finish after exponent
			if (cf_k >= left) begin
				n_phase = PH_CODE;
				n_pend  = 8'd0;
				n_pos   = 15'd0;
				if (e_ch == 2'd3) begin
					res.line_end = 1'b1;
					do_nl        = 1'b1;
				end else begin
					n_ch = e_ch + 2'd1;
				end
			end
		end

		if (do_pf) begin
			pf_over        = pf_k > {17'd0, left};
			res_valid      = 1'b1;
			res.x_start    = e_pos;
			res.fill_value = pf_val;
			if (pf_over) begin
				res.kind       = rsrd_pkg::KIND_OVERRUN;
				res.fill_count = left;
				res.line_end   = 1'b1;
				do_nl          = 1'b1;
			end else begin
				res.kind       = rsrd_pkg::KIND_PIXEL;
				res.fill_count = pf_k[14:0];
				n_pos          = e_pos + pf_k[14:0];
				if (pf_k[14:0] == left) begin
					res.line_end = 1'b1;
					do_nl        = 1'b1;
				end
			end
		end

		if (do_nl) begin
			n_mode   = MODE_FIRST;
			n_bip    = 2'd0;
			n_gather = 32'd0;
			n_shift  = 2'd0;
			n_pos    = 15'd0;
			n_ch     = 2'd0;
			n_phase  = PH_CODE;
			n_pend   = 8'd0;
		end

		res_valid = res_valid && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rsrd_pkg::LINE_WIDTH_RESET;
			mode_q   <= MODE_FIRST;
			phase_q  <= PH_CODE;
			bip_q    <= 2'd0;
			gather_q <= 32'd0;
			prev_q   <= 32'd0;
			shift_q  <= 2'd0;
			pos_q    <= 15'd0;
			ch_q     <= 2'd0;
			pend_q   <= 8'd0;
			err_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				width_q <= cfg_wr_data;
			end
			if (accept) begin
				mode_q   <= n_mode;
				phase_q  <= n_phase;
				bip_q    <= n_bip;
				gather_q <= n_gather;
				prev_q   <= n_prev;
				shift_q  <= n_shift;
				pos_q    <= n_pos;
				ch_q     <= n_ch;
				pend_q   <= n_pend;
				err_q    <= n_err;
			end
		end
	end

	`RSRD_ASSERT_IMPLY(a_err_waits_line, clk, arst_n, err_q, mode_q == MODE_FIRST)
	`RSRD_ASSERT_IMPLY(a_chan_no_gather, clk, arst_n, mode_q == MODE_CHAN,
		bip_q == 2'd0 && gather_q == 32'd0)
	`RSRD_ASSERT_IMPLY(a_chan_state_only, clk, arst_n, ch_q != 2'd0 || pend_q != 8'd0,
		mode_q == MODE_CHAN)

endmodule

/* hw/rtl/rsrd_out_queue.sv */
// Two-entry result buffer: output register plus skid entry.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsrd_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rsrd_pkg::result_t    push_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output rsrd_pkg::result_t    out_data,
	output logic                 space
);

	logic              out_valid_q;
	logic              skid_valid_q;
	rsrd_pkg::result_t out_q;
	rsrd_pkg::result_t skid_q;
	logic              pop;

	assign pop       = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign space     = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q) begin
				out_valid_q <= push;
			end else if (pop) begin
				// advance the skid entry, or refill straight from the parser
				if (skid_valid_q) begin
					skid_valid_q <= push;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q) begin
			out_q <= push_data;
		end else if (pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`RSRD_ASSERT_IMPLY(a_skid_behind_head, clk, arst_n, skid_valid_q, out_valid_q)
	`RSRD_ASSERT_IMPLY(a_push_has_room, clk, arst_n, push, !skid_valid_q || pop)
	`RSRD_ASSERT_NEXT(a_skid_moves_up, clk, arst_n, pop && skid_valid_q, out_valid_q)

endmodule

/* hw/rtl/rgbe_scanline_rle_decoder_unit.sv */
// Top level of the RGBE scanline RLE decoder: parser and result buffer.
`timescale 1ns / 1ps
// A fill descriptor is registered in the output register, or the skid entry if held.
// Throughput: one byte per cycle while the buffer has room, set by the parser update.
// A two-entry result buffer keeps bytes flowing while a finished fill waits.
// Reset (arst_n low) clears parser state, sets line_width to 512 and empties the
// buffer at once; there is no clearing pass.

module rgbe_scanline_rle_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	rsrd_byte_if.sink   data_ch,
	rsrd_fill_if.source fill_ch,
	input  logic        cfg_wr_en,
	input  logic [14:0] cfg_wr_data
);

	logic              accept;
	logic              res_valid;
	rsrd_pkg::result_t res;
	rsrd_pkg::result_t head;
	logic              space;

	assign data_ch.ready = space;
	assign accept        = data_ch.valid && space;

	rsrd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_ch.data_byte),
		.line_start  (data_ch.line_start),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res_valid   (res_valid),
		.res         (res)
	);

	rsrd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_ready (fill_ch.ready),
		.out_valid (fill_ch.valid),
		.out_data  (head),
		.space     (space)
	);

	assign fill_ch.kind       = head.kind;
	assign fill_ch.channel    = head.channel;
	assign fill_ch.x_start    = head.x_start;
	assign fill_ch.fill_count = head.fill_count;
	assign fill_ch.fill_value = head.fill_value;
	assign fill_ch.line_end   = head.line_end;

endmodule
